// File: hdl/utf8v_pkg.sv
// Package for the UTF-8 stream validator: word, result and state types,
// byte range constants and the shared clear value. No dependencies.
package utf8v_pkg;

    localparam logic [7:0] C_CONT_LOW     = 8'h80;
    localparam logic [7:0] C_CONT_HIGH    = 8'hBF;
    localparam logic [7:0] C_ASCII_MAX    = 8'h7F;
    localparam logic [7:0] C_LEAD2_LOW    = 8'hC2;
    localparam logic [7:0] C_LEAD2_HIGH   = 8'hDF;
    localparam logic [7:0] C_LEAD3_LOW    = 8'hE0;
    localparam logic [7:0] C_LEAD3_HIGH   = 8'hEF;
    localparam logic [7:0] C_LEAD3_SURR   = 8'hED;
    localparam logic [7:0] C_LEAD4_LOW    = 8'hF0;
    localparam logic [7:0] C_LEAD4_HIGH   = 8'hF4;
    localparam logic [7:0] C_E0_CONT_MIN  = 8'hA0;
    localparam logic [7:0] C_ED_CONT_MAX  = 8'h9F;
    localparam logic [7:0] C_F0_CONT_MIN  = 8'h90;
    localparam logic [7:0] C_F4_CONT_MAX  = 8'h8F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_text;
    } t_word;

    typedef struct packed {
        logic error_seen;
        logic verdict_ready;
        logic text_valid;
    } t_result;

    typedef struct packed {
        logic [1:0] pending;
        logic [7:0] next_min;
        logic [7:0] next_max;
        logic       error_flag;
    } t_state;

    localparam t_state C_STATE_CLEAR = '{
        pending:    2'd0,
        next_min:   C_CONT_LOW,
        next_max:   C_CONT_HIGH,
        error_flag: 1'b0
    };

endpackage

// File: hdl/utf8_stream_validator_unit.sv
// UTF-8 stream validator, one byte per word, with per-buffer verdict on the end word.
// Throughput is one word per clock while the output is not stalled; each word passes
// through the input register and then the result register around the byte
// decode. The decode state (open continuations, allowed range of the next byte and
// the sticky error) is updated as a word moves from the input register to the
// result register, and is cleared by every end word. Each word gives one result.
// Depends on utf8v_pkg and utf8v_check.
module utf8_stream_validator_unit
    import utf8v_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_error_seen,
    output logic       o_verdict_ready,
    output logic       o_text_valid
);

    logic    r_in_valid;
    t_word   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;

    t_state  n_state;
    t_result w_result;
    logic    w_out_free;
    logic    w_move;
    logic    w_accept;

    assign w_out_free = ~r_out_valid | ~i_stall;
    assign w_move     = r_in_valid & w_out_free;
    assign o_stall    = r_in_valid & ~w_out_free;
    assign w_accept   = i_valid & ~o_stall;

    utf8v_check u_check (
        .i_word       (r_in),
        .i_state      (r_state),
        .o_state_next (n_state),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= C_STATE_CLEAR;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            // advance decode state only as a word leaves the input register
            if (w_move) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.data_byte   <= i_data_byte;
            r_in.has_byte    <= i_has_byte;
            r_in.end_of_text <= i_end_of_text;
        end
        if (w_move) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_error_seen    = r_out.error_seen;
    assign o_verdict_ready = r_out.verdict_ready;
    assign o_text_valid    = r_out.text_valid;

`ifndef NO_ASSERTIONS
    a_verdict_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict_ready) |-> (o_text_valid != o_error_seen))
        else $error("verdict and error flag disagree");

    a_no_valid_without_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_verdict_ready) |-> !o_text_valid)
        else $error("text_valid set without verdict");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_in.end_of_text) |=> (r_state == C_STATE_CLEAR))
        else $error("state not cleared after end word");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("stall raised with empty input register");
`endif

endmodule

// File: hdl/utf8v_check.sv
// Byte decode for the UTF-8 stream validator: next state and result for one word.
// Depends on utf8v_pkg.
module utf8v_check
    import utf8v_pkg::*;
(
    input  t_word   i_word,
    input  t_state  i_state,
    output t_state  o_state_next,
    output t_result o_result
);

    t_state w_after;
    logic   w_err;

    always_comb begin
        w_after = i_state;
        if (i_word.has_byte) begin
            w_after.next_min = C_CONT_LOW;
            w_after.next_max = C_CONT_HIGH;
            if (i_state.pending != 2'd0) begin
                if (i_word.data_byte < i_state.next_min ||
                    i_word.data_byte > i_state.next_max) begin
                    // drop the open sequence; next byte is a new lead
                    w_after.error_flag = 1'b1;
                    w_after.pending    = 2'd0;
                end else begin
                    w_after.pending = i_state.pending - 2'd1;
                end
            end else if (i_word.data_byte == 8'h00) begin
                w_after.error_flag = 1'b1;
            end else if (i_word.data_byte <= C_ASCII_MAX) begin
                w_after.pending = 2'd0;
            end else if (i_word.data_byte >= C_LEAD2_LOW &&
                         i_word.data_byte <= C_LEAD2_HIGH) begin
                w_after.pending = 2'd1;
            end else if (i_word.data_byte >= C_LEAD3_LOW &&
                         i_word.data_byte <= C_LEAD3_HIGH) begin
                w_after.pending = 2'd2;
                if (i_word.data_byte == C_LEAD3_LOW) begin
                    w_after.next_min = C_E0_CONT_MIN;
                end else if (i_word.data_byte == C_LEAD3_SURR) begin
                    w_after.next_max = C_ED_CONT_MAX;
                end
            end else if (i_word.data_byte >= C_LEAD4_LOW &&
                         i_word.data_byte <= C_LEAD4_HIGH) begin
                w_after.pending = 2'd3;
                if (i_word.data_byte == C_LEAD4_LOW) begin
                    w_after.next_min = C_F0_CONT_MIN;
                end else if (i_word.data_byte == C_LEAD4_HIGH) begin
                    w_after.next_max = C_F4_CONT_MAX;
                end
            end else begin
                // stray continuation or forbidden lead
                w_after.error_flag = 1'b1;
            end
        end
    end

    assign w_err = w_after.error_flag | (w_after.pending != 2'd0);

    always_comb begin
        if (i_word.end_of_text) begin
            o_state_next           = C_STATE_CLEAR;
            o_result.error_seen    = w_err;
            o_result.verdict_ready = 1'b1;
            o_result.text_valid    = ~w_err;
        end else begin
            o_state_next           = w_after;
            o_result.error_seen    = w_after.error_flag;
            o_result.verdict_ready = 1'b0;
            o_result.text_valid    = 1'b0;
        end
    end

endmodule
